// File: rtl/core/tpb_pkg.sv
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types, constants and reset values for the pausable timer bank.
// ----------------------------------------------------------------------------
package tpb_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int COUNT_WIDTH  = 24;
  localparam int NUM_REGS     = 6;
  localparam int NUM_TIMERS   = (NUM_CHANNELS < NUM_REGS) ? NUM_CHANNELS : NUM_REGS;
  localparam int IDX_W        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int ACT_W   = 3;
  localparam int CH_W    = 3;
  localparam int KIND_W  = 2;
  localparam int TICKS_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [ACT_W-1:0] {
    ACT_START  = 3'd0,
    ACT_PAUSE  = 3'd1,
    ACT_RESUME = 3'd2,
    ACT_CANCEL = 3'd3,
    ACT_STOP   = 3'd4,
    ACT_TICK   = 3'd5
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_OK      = 2'd0,
    KIND_IGNORED = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_SCAN = 2'd2
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic exec;     // carry out a non-tick action and load its result
    logic step;     // visit the current scan channel and advance
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic out_free;
    logic hit;       // current scan channel expires
    logic scan_end;
  } status_t;

  function automatic logic [COUNT_WIDTH-1:0] reset_duration(input int idx);
    logic [23:0] val;
    case (idx)
      0:       val = 24'd15000;
      1:       val = 24'd10000;
      2:       val = 24'd5000;
      3:       val = 24'd5000;
      4:       val = 24'd10000;
      5:       val = 24'd10000;
      default: val = 24'd0;
    endcase
    return COUNT_WIDTH'(val);
  endfunction

endpackage

// File: rtl/core/pausable_timer_bank.sv
// ----------------------------------------------------------------------------
// pausable_timer_bank
// Bank of one-shot countdown timers with start, pause, resume, cancel,
// stop-all and tick actions.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Start, pause, resume, cancel, stop-all
// and unknown actions give one result. A tick scan visits one channel per
// cycle, holding on an expiry while the output register is occupied, through
// a single shared decrement, and each expiring channel gives one result in
// rising channel order, the final one flagged by last_o; a tick that expires
// nothing gives no result. Backpressure on the output adds cycles only where
// a result has to wait for the output register.
// Duration registers may be written at any time the bank is idle.
module pausable_timer_bank import tpb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [CH_W-1:0]       channel_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     result_kind_o,
  output logic [CH_W-1:0]       result_channel_o,
  output logic [TICKS_W-1:0]    remaining_ticks_o,
  output logic                  last_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_stall_o = !in_ready;

  tpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  tpb_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .action_i          (action_i),
    .channel_i         (channel_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_kind_o     (result_kind_o),
    .result_channel_o  (result_channel_o),
    .remaining_ticks_o (remaining_ticks_o),
    .last_o            (last_o)
  );

endmodule

// File: rtl/core/tpb_ctrl.sv
// ----------------------------------------------------------------------------
// tpb_ctrl
// Sequencer: takes one transaction, runs the action or the tick scan.
// ----------------------------------------------------------------------------
module tpb_ctrl import tpb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.is_tick) state_d = ST_SCAN;
        else if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if ((!status_i.hit || status_i.out_free) && status_i.scan_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.step    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = !status_i.is_tick && status_i.out_free;
      end
      ST_SCAN: begin
        // hold on an expiry while the output register is still occupied
        cmd_o.step = !status_i.hit || status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/tpb_datapath.sv
// ----------------------------------------------------------------------------
// tpb_datapath
// Timer state, duration registers, action logic, scan decrementer, output.
// ----------------------------------------------------------------------------
module tpb_datapath import tpb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [CH_W-1:0]       channel_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     result_kind_o,
  output logic [CH_W-1:0]       result_channel_o,
  output logic [TICKS_W-1:0]    remaining_ticks_o,
  output logic                  last_o
);

  logic [COUNT_WIDTH-1:0] dur_q [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  act_q, act_d, pau_q, pau_d, expiring;
  logic                   stop_q, stop_d;
  logic [IDX_W-1:0]       scan_q;
  logic [ACT_W-1:0]       act_in_q;
  logic [CH_W-1:0]        ch_q;

  logic                   out_valid_q;
  logic [KIND_W-1:0]      kind_q, kind_d;
  logic [CH_W-1:0]        rch_q, rch_d;
  logic [TICKS_W-1:0]     rem_q, rem_d;
  logic                   last_q, last_d;
  logic                   load;

  logic                   cfg_ch;
  logic [IDX_W-1:0]       idx;
  logic [COUNT_WIDTH-1:0] cnt_sel, dur_sel;
  logic                   act_sel, pau_sel, more_after;

  assign cfg_ch  = 32'(ch_q) < NUM_TIMERS;
  assign idx     = ch_q[IDX_W-1:0];
  assign cnt_sel = cfg_ch ? cnt_q[idx] : '0;
  assign dur_sel = cfg_ch ? dur_q[idx] : '0;
  assign act_sel = cfg_ch && act_q[idx];
  assign pau_sel = cfg_ch && pau_q[idx];

  always_comb begin
    more_after = 1'b0;
    for (int c = 0; c < NUM_TIMERS; c++) begin
      expiring[c] = act_q[c] && !pau_q[c] && (cnt_q[c] <= COUNT_WIDTH'(1));
      if (IDX_W'(c) > scan_q && expiring[c]) more_after = 1'b1;
    end
  end

  assign status_o.is_tick  = act_in_q == ACT_TICK;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.hit      = expiring[scan_q];
  assign status_o.scan_end = scan_q == IDX_W'(NUM_TIMERS - 1);

  assign load = cmd_i.exec || (cmd_i.step && status_o.hit);

  always_comb begin
    act_d  = act_q;
    pau_d  = pau_q;
    stop_d = stop_q;
    for (int c = 0; c < NUM_TIMERS; c++) cnt_d[c] = cnt_q[c];
    kind_d = KIND_IGNORED;
    rch_d  = ch_q;
    rem_d  = '0;
    last_d = 1'b1;

    if (cmd_i.exec) begin
      case (act_in_q)
        ACT_START: begin
          if (cfg_ch && stop_q) begin
            rem_d = TICKS_W'(cnt_sel);
          end else if (cfg_ch) begin
            act_d[idx] = 1'b1;
            pau_d[idx] = 1'b0;
            cnt_d[idx] = dur_sel;
            kind_d     = KIND_OK;
            rem_d      = TICKS_W'(dur_sel);
          end
        end
        ACT_PAUSE: begin
          if (cfg_ch) rem_d = TICKS_W'(cnt_sel);
          if (act_sel && !pau_sel) begin
            pau_d[idx] = 1'b1;
            kind_d     = KIND_OK;
          end
        end
        ACT_RESUME: begin
          if (cfg_ch) rem_d = TICKS_W'(cnt_sel);
          if (act_sel && pau_sel) begin
            pau_d[idx] = 1'b0;
            kind_d     = KIND_OK;
          end
        end
        ACT_CANCEL: begin
          if (cfg_ch) begin
            act_d[idx] = 1'b0;
            pau_d[idx] = 1'b0;
            cnt_d[idx] = '0;
            kind_d     = KIND_OK;
          end
        end
        ACT_STOP: begin
          rch_d = '0;
          if (!stop_q) begin
            stop_d = 1'b1;
            act_d  = '0;
            pau_d  = '0;
            for (int c = 0; c < NUM_TIMERS; c++) cnt_d[c] = '0;
            kind_d = KIND_OK;
          end
        end
        default: begin
          kind_d = KIND_IGNORED;
        end
      endcase
    end else if (cmd_i.step) begin
      rch_d  = CH_W'(scan_q);
      kind_d = KIND_EXPIRED;
      last_d = !more_after;
      if (status_o.hit) begin
        act_d[scan_q] = 1'b0;
        pau_d[scan_q] = 1'b0;
        cnt_d[scan_q] = '0;
      end else if (act_q[scan_q] && !pau_q[scan_q]) begin
        cnt_d[scan_q] = cnt_q[scan_q] - COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_TIMERS; c++) begin
        dur_q[c] <= reset_duration(c);
        cnt_q[c] <= '0;
      end
      act_q       <= '0;
      pau_q       <= '0;
      stop_q      <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      act_in_q    <= '0;
    end else begin
      if (cfg_we_i && 32'(cfg_idx_i) < NUM_TIMERS) begin
        dur_q[cfg_idx_i[IDX_W-1:0]] <= COUNT_WIDTH'(cfg_data_i);
      end
      for (int c = 0; c < NUM_TIMERS; c++) cnt_q[c] <= cnt_d[c];
      act_q  <= act_d;
      pau_q  <= pau_d;
      stop_q <= stop_d;
      if (cmd_i.capture) act_in_q <= action_i;
      if (cmd_i.step) begin
        scan_q <= status_o.scan_end ? '0 : scan_q + IDX_W'(1);
      end
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) ch_q <= channel_i;
    if (load) begin
      kind_q <= kind_d;
      rch_q  <= rch_d;
      rem_q  <= rem_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_q;
  assign result_channel_o  = rch_q;
  assign remaining_ticks_o = rem_q;
  assign last_o            = last_q;

endmodule
